### hdl/dcd_pkg.sv
package dcd_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VertW       = $clog2(MaxVertices);
  localparam int unsigned CntW        = VertW + 1;
  localparam int unsigned CfgW        = 5;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DETECT = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0
  } reg_idx_e;

  typedef logic [MaxVertices-1:0] row_t;

  // one saved search frame: vertex and next neighbor to try
  typedef struct packed {
    logic [VertW-1:0] vertex;
    logic [CntW-1:0]  next;
  } frame_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } eng_status_t;

endpackage

### hdl/dcd_adj_matrix.sv
module dcd_adj_matrix
  import dcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             add_i,
  input  logic             clear_i,
  input  logic [VertW-1:0] src_i,
  input  logic [VertW-1:0] dst_i,
  input  logic [VertW-1:0] rd_idx_i,
  output row_t             rd_row_o
);

  row_t rows_q [MaxVertices];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxVertices; i++) begin
        rows_q[i] <= '0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < MaxVertices; i++) begin
        rows_q[i] <= '0;
      end
    end else if (add_i) begin
      rows_q[src_i][dst_i] <= 1'b1;
    end
  end

  assign rd_row_o = rows_q[rd_idx_i];

endmodule

### hdl/dcd_dfs_engine.sv
module dcd_dfs_engine
  import dcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CntW-1:0]  n_i,
  input  row_t             row_i,
  output logic [VertW-1:0] row_idx_o,
  output eng_status_t      status_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROOT = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  root_q, root_d;
  logic [VertW-1:0] u_q, u_d;
  logic [CntW-1:0]  j_q, j_d;
  logic [CntW-1:0]  depth_q, depth_d;
  row_t             visited_q, visited_d;
  row_t             on_path_q, on_path_d;
  frame_t           stack_q [MaxVertices];

  logic             push;
  logic [VertW-1:0] push_idx;
  logic [VertW-1:0] pop_idx;
  frame_t           pop_frame;
  logic [VertW-1:0] j_idx;
  logic [VertW-1:0] root_idx;
  logic             done;
  logic             found;

  assign j_idx     = j_q[VertW-1:0];
  assign root_idx  = root_q[VertW-1:0];
  assign push_idx  = VertW'(depth_q - CntW'(1));
  assign pop_idx   = VertW'(depth_q - CntW'(2));
  assign pop_frame = stack_q[pop_idx];
  assign row_idx_o = u_q;

  always_comb begin
    state_d   = state_q;
    root_d    = root_q;
    u_d       = u_q;
    j_d       = j_q;
    depth_d   = depth_q;
    visited_d = visited_q;
    on_path_d = on_path_q;
    push      = 1'b0;
    done      = 1'b0;
    found     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          root_d    = '0;
          depth_d   = '0;
          visited_d = '0;
          on_path_d = '0;
          state_d   = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_q >= n_i) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end else if (visited_q[root_idx]) begin
          root_d = root_q + CntW'(1);
        end else begin
          u_d                 = root_idx;
          j_d                 = '0;
          depth_d             = CntW'(1);
          visited_d[root_idx] = 1'b1;
          on_path_d[root_idx] = 1'b1;
          state_d             = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_q >= n_i) begin
          // neighbors exhausted: leave the path and return
          on_path_d[u_q] = 1'b0;
          depth_d        = depth_q - CntW'(1);
          if (depth_q == CntW'(1)) begin
            root_d  = root_q + CntW'(1);
            state_d = ST_ROOT;
          end else begin
            u_d = pop_frame.vertex;
            j_d = pop_frame.next;
          end
        end else if (row_i[j_idx]) begin
          if (on_path_q[j_idx]) begin
            done    = 1'b1;
            found   = 1'b1;
            state_d = ST_IDLE;
          end else if (visited_q[j_idx]) begin
            j_d = j_q + CntW'(1);
          end else begin
            push             = 1'b1;
            u_d              = j_idx;
            j_d              = '0;
            depth_d          = depth_q + CntW'(1);
            visited_d[j_idx] = 1'b1;
            on_path_d[j_idx] = 1'b1;
          end
        end else begin
          j_d = j_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      root_q    <= '0;
      u_q       <= '0;
      j_q       <= '0;
      depth_q   <= '0;
      visited_q <= '0;
      on_path_q <= '0;
    end else begin
      state_q   <= state_d;
      root_q    <= root_d;
      u_q       <= u_d;
      j_q       <= j_d;
      depth_q   <= depth_d;
      visited_q <= visited_d;
      on_path_q <= on_path_d;
    end
  end

  // frames below the top live here; the top frame sits in u_q and j_q
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[push_idx] <= '{vertex: u_q, next: j_q + CntW'(1)};
    end
  end

  assign status_o = '{busy: (state_q != ST_IDLE), done: done, found: found};

endmodule

### hdl/directed_cycle_detector_core.sv
// directed cycle detector
// request channel: in_valid_i / in_stall_o carry req_type_i, src_vertex_i and
// dst_vertex_i; a request is taken at a clock edge with valid high, stall low
// add edge and clear requests give no result; an add whose endpoint is at or
// above the vertex count is dropped
// a detect request gives one result on out_valid_o / out_stall_i with
// cycle_found_o; the depth-first search tests one neighbor bit per cycle in
// a single compare step while it scans, apart from the steps that return up
// the path; the result is offered in the cycle after the search ends, and
// in_stall_o stays high for the whole search
// the result sits in an output register; while the receiver holds
// out_stall_i high on a waiting result, in_stall_o is high and no request of
// any kind is taken
// vertex_count is set over the apb port at byte address 0, values above the
// matrix size act as the full size
// reset (rst_ni low) empties the adjacency matrix at once, sets the vertex
// count to 16 and drops any waiting result
module directed_cycle_detector_core
  import dcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [VertW-1:0]    src_vertex_i,
  input  logic [VertW-1:0]    dst_vertex_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                cycle_found_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CfgW-1:0]  vertex_count_q;
  logic [CntW-1:0]  n_act;
  logic             reg_hit;
  logic             accept;
  logic             add_ok;
  logic             clear_req;
  logic             start;
  row_t             row;
  logic [VertW-1:0] row_idx;
  eng_status_t      eng;
  logic             out_valid_q, out_valid_d;
  logic             found_q;

  // register decode, word address only
  assign reg_hit = (paddr[ApbAddrW-1:2] == REG_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? ApbDataW'(vertex_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= CfgW'(MaxVertices);
    end else if (psel && penable && pwrite && reg_hit) begin
      vertex_count_q <= pwdata[CfgW-1:0];
    end
  end

  // counts beyond the matrix clamp to its size
  assign n_act = (vertex_count_q > CfgW'(MaxVertices)) ? CntW'(MaxVertices)
                                                       : CntW'(vertex_count_q);

  // stall during a search and while a waiting result is held back
  assign in_stall_o = eng.busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign add_ok    = accept && (req_type_i == REQ_ADD)
                     && (CntW'(src_vertex_i) < n_act) && (CntW'(dst_vertex_i) < n_act);
  assign clear_req = accept && (req_type_i == REQ_CLEAR);
  assign start     = accept && (req_type_i == REQ_DETECT);

  dcd_adj_matrix u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .add_i    (add_ok),
    .clear_i  (clear_req),
    .src_i    (src_vertex_i),
    .dst_i    (dst_vertex_i),
    .rd_idx_i (row_idx),
    .rd_row_o (row)
  );

  dcd_dfs_engine u_dfs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .n_i       (n_act),
    .row_i     (row),
    .row_idx_o (row_idx),
    .status_o  (eng)
  );

  // output register: the slot is always free by the time a search ends
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (eng.done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng.done) begin
      found_q <= eng.found;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cycle_found_o = found_q;

endmodule
